[sv/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the source text tokenizer
// Token kinds, error codes, scan modes and the keyword table.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int INDEX_BITS    = 20;
	localparam int LINE_BITS     = 16;
	localparam int KEYWORD_CHARS = 6;
	localparam int KW_COUNT      = 27;
	localparam int WLEN_BITS     = 3;

	localparam logic [INDEX_BITS-1:0] IDX_MAX  = '1;
	localparam logic [LINE_BITS-1:0]  LINE_MAX = '1;

	localparam logic [5:0] K_IDENT  = 6'd27;
	localparam logic [5:0] K_INT    = 6'd28;
	localparam logic [5:0] K_REAL   = 6'd29;
	localparam logic [5:0] K_STRING = 6'd30;
	localparam logic [5:0] K_END    = 6'd31;
	localparam logic [5:0] K_ERROR  = 6'd32;
	localparam logic [5:0] K_ASSIGN = 6'd33;
	localparam logic [5:0] K_EQEQ   = 6'd34;
	localparam logic [5:0] K_ARROW  = 6'd35;
	localparam logic [5:0] K_EQ     = 6'd36;
	localparam logic [5:0] K_LE     = 6'd37;
	localparam logic [5:0] K_LT     = 6'd38;
	localparam logic [5:0] K_GE     = 6'd39;
	localparam logic [5:0] K_GT     = 6'd40;
	localparam logic [5:0] K_NE     = 6'd41;
	localparam logic [5:0] K_SLASH  = 6'd42;
	localparam logic [5:0] K_PLUS   = 6'd43;
	localparam logic [5:0] K_MINUS  = 6'd44;
	localparam logic [5:0] K_STAR   = 6'd45;
	localparam logic [5:0] K_LPAR   = 6'd46;
	localparam logic [5:0] K_RPAR   = 6'd47;
	localparam logic [5:0] K_LBRK   = 6'd48;
	localparam logic [5:0] K_RBRK   = 6'd49;
	localparam logic [5:0] K_LBRC   = 6'd50;
	localparam logic [5:0] K_RBRC   = 6'd51;
	localparam logic [5:0] K_RANGE  = 6'd52;
	localparam logic [5:0] K_DOT    = 6'd53;
	localparam logic [5:0] K_SEMI   = 6'd54;
	localparam logic [5:0] K_COMMA  = 6'd55;

	typedef enum logic [2:0] {
		E_NONE        = 3'd0,
		E_LONE_COLON  = 3'd1,
		E_UNKNOWN     = 3'd2,
		E_OPEN_STRING = 3'd3,
		E_OPEN_ESCAPE = 3'd4,
		E_OPEN_COMMENT = 3'd5
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE          = 4'd0,
		M_IDENT         = 4'd1,
		M_NUMBER        = 4'd2,
		M_NUMBER_DOT    = 4'd3,
		M_REAL          = 4'd4,
		M_STRING        = 4'd5,
		M_STRING_ESC    = 4'd6,
		M_PAIR          = 4'd7,
		M_LINE_COMMENT  = 4'd8,
		M_BLOCK_COMMENT = 4'd9,
		M_BLOCK_STAR    = 4'd10
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]            token_kind;
		logic [2:0]            error_code;
		logic [INDEX_BITS-1:0] token_start;
		logic [INDEX_BITS-1:0] token_length;
		logic [LINE_BITS-1:0]  start_line;
		logic [LINE_BITS-1:0]  start_column;
		logic                  last_of_run;
	} out_beat_t;

	typedef logic [8*KEYWORD_CHARS-1:0] kw_word_t;

	// Keywords packed with the first character in the low byte, zero padded.
	function automatic kw_word_t kw_entry(input int k);
		logic [8*KEYWORD_CHARS-1:0] w;
		w = '0;
		case (k)
			0:  w = kw_word_t'(24'h726176);
			1:  w = kw_word_t'(16'h6669);
			2:  w = kw_word_t'(32'h6e656874);
			3:  w = kw_word_t'(32'h65736c65);
			4:  w = kw_word_t'(24'h646e65);
			5:  w = kw_word_t'(32'h706f6f6c);
			6:  w = kw_word_t'(32'h74697865);
			7:  w = kw_word_t'(48'h6e7275746572);
			8:  w = kw_word_t'(40'h746e697270);
			9:  w = kw_word_t'(40'h656c696877);
			10: w = kw_word_t'(24'h726f66);
			11: w = kw_word_t'(32'h636e7566);
			12: w = kw_word_t'(32'h65757274);
			13: w = kw_word_t'(40'h65736c6166);
			14: w = kw_word_t'(32'h656e6f6e);
			15: w = kw_word_t'(24'h646e61);
			16: w = kw_word_t'(16'h726f);
			17: w = kw_word_t'(24'h726f78);
			18: w = kw_word_t'(24'h746f6e);
			19: w = kw_word_t'(32'h74736574);
			20: w = kw_word_t'(48'h747265737361);
			21: w = kw_word_t'(16'h7369);
			22: w = kw_word_t'(16'h6e69);
			23: w = kw_word_t'(24'h746e69);
			24: w = kw_word_t'(32'h6c616572);
			25: w = kw_word_t'(32'h6c6f6f62);
			26: w = kw_word_t'(48'h676e69727473);
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] n;
		case (k)
			1, 16, 21, 22: n = 3'd2;
			0, 4, 10, 15, 17, 18, 23: n = 3'd3;
			8, 9, 13: n = 3'd5;
			7, 20, 26: n = 3'd6;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

[sv/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one byte a beat in, up to three tokens a byte out.
// ----------------------------------------------------------------------------
// A token leaves the result register in the cycle after the byte that
// settles it is taken. Throughput: one byte a cycle; a byte that yields more
// than one token (at most three) stalls the input while the result queue
// drains, and the input also stalls while the receiver stalls.
// Reset clears all scan state: position 0, line 1, column 1, mode idle.
module source_text_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stt_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stt_pkg::out_beat_t out_data
);
	import stt_pkg::*;

	// Scan state
	mode_t                 mode_q;
	logic [INDEX_BITS-1:0] pos_q, tpos_q, dpos_q;
	logic [LINE_BITS-1:0]  line_q, col_q, tline_q, tcol_q, dline_q, dcol_q;
	kw_word_t              kbuf_q;
	logic [WLEN_BITS-1:0]  wlen_q;
	logic [7:0]            pend_q, quote_q;

	// Result queue: three slots, drained from slot 0.
	out_beat_t   q_q [3];
	logic [1:0]  qcnt_q;

	// Combinational next state and results of this byte.
	mode_t                 mode_n;
	logic [INDEX_BITS-1:0] tpos_n, dpos_n, pos_n;
	logic [LINE_BITS-1:0]  tline_n, tcol_n, dline_n, dcol_n, line_n, col_n;
	kw_word_t              kbuf_n;
	logic [WLEN_BITS-1:0]  wlen_n;
	logic [7:0]            pend_n, quote_n;
	out_beat_t             res [3];
	logic [1:0]            nres;

	logic [7:0]            c;
	logic                  eot, accept, q_pop;
	logic [INDEX_BITS-1:0] pos_inc;
	logic [5:0]            wkind;

	assign c       = in_data.text_byte;
	assign eot     = in_data.end_of_text;
	assign pos_inc = (pos_q == IDX_MAX) ? pos_q : pos_q + 1'b1;
	assign q_pop   = (qcnt_q != 2'd0) && !out_stall;
	// Room for up to three new results once the head leaves.
	assign in_stall = (qcnt_q > 2'd1) || ((qcnt_q == 2'd1) && out_stall);
	assign accept  = in_valid && !in_stall;

	assign out_valid = (qcnt_q != 2'd0);
	assign out_data  = q_q[0];

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// Keyword match against the buffered word.
	always_comb begin
		wkind = K_IDENT;
		if (wlen_q <= WLEN_BITS'(KEYWORD_CHARS)) begin
			for (int k = KW_COUNT - 1; k >= 0; k--) begin
				if (kbuf_q == kw_entry(k) && wlen_q == kw_len(k))
					wkind = 6'(k);
			end
		end
	end

	always_comb begin
		mode_t                 m;
		logic [INDEX_BITS-1:0] sp;
		logic [LINE_BITS-1:0]  sl, sc;
		logic [7:0]            pc;
		logic                  do_idle, do_pair;
		logic [5:0]            k;
		logic                  emit_ok;
		m = mode_q;
		sp = tpos_q; sl = tline_q; sc = tcol_q;
		pc = pend_q;
		kbuf_n = kbuf_q; wlen_n = wlen_q; quote_n = quote_q;
		dpos_n = dpos_q; dline_n = dline_q; dcol_n = dcol_q;
		do_idle = 1'b0; do_pair = 1'b0;
		nres = 2'd0;
		k = K_ERROR;
		emit_ok = 1'b0;
		for (int i = 0; i < 3; i++) res[i] = '0;

		if (eot) begin
			case (mode_q)
				M_IDENT: begin
					res[nres] = {wkind, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_NUMBER: begin
					res[nres] = {K_INT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_NUMBER_DOT: begin
					res[0] = {K_INT, E_NONE, sp, dpos_q - sp, sl, sc, 1'b0};
					res[1] = {K_DOT, E_NONE, dpos_q, pos_q - dpos_q, dline_q, dcol_q, 1'b0};
					nres = 2'd2;
				end
				M_REAL: begin
					res[nres] = {K_REAL, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_STRING: begin
					res[nres] = {K_ERROR, E_OPEN_STRING, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_STRING_ESC: begin
					res[nres] = {K_ERROR, E_OPEN_ESCAPE, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_BLOCK_COMMENT, M_BLOCK_STAR: begin
					res[nres] = {K_ERROR, E_OPEN_COMMENT, sp, pos_q - sp, sl, sc, 1'b0};
					nres = nres + 1'b1;
				end
				M_PAIR: begin
					case (pc)
						8'h3a: res[nres] = {K_ERROR, E_LONE_COLON, sp, pos_q - sp, sl, sc, 1'b0};
						8'h3d: res[nres] = {K_EQ, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						8'h3c: res[nres] = {K_LT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						8'h3e: res[nres] = {K_GT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						8'h2f: res[nres] = {K_SLASH, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						default: res[nres] = {K_DOT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
					endcase
					nres = nres + 1'b1;
				end
				default: ;
			endcase
			res[nres] = {K_END, E_NONE, pos_q, {INDEX_BITS{1'b0}}, line_q, col_q, 1'b0};
			nres = nres + 1'b1;
			m = M_IDLE;
			sp = '0; sl = LINE_BITS'(1); sc = LINE_BITS'(1);
			kbuf_n = '0; wlen_n = '0; pc = '0; quote_n = '0;
			dpos_n = '0; dline_n = LINE_BITS'(1); dcol_n = LINE_BITS'(1);
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
						if (wlen_q < WLEN_BITS'(KEYWORD_CHARS)) begin
							kbuf_n[8*wlen_q +: 8] = c;
							wlen_n = wlen_q + 1'b1;
						end else if (wlen_q == WLEN_BITS'(KEYWORD_CHARS)) begin
							wlen_n = wlen_q + 1'b1;
						end
					end else begin
						res[0] = {wkind, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						nres = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (c == 8'h2e) begin
						dpos_n = pos_q; dline_n = line_q; dcol_n = col_q;
						m = M_NUMBER_DOT;
					end else if (!is_digit(c)) begin
						res[0] = {K_INT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						nres = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_NUMBER_DOT: begin
					if (is_digit(c)) begin
						m = M_REAL;
					end else begin
						res[0] = {K_INT, E_NONE, sp, dpos_q - sp, sl, sc, 1'b0};
						nres = 2'd1;
						sp = dpos_q; sl = dline_q; sc = dcol_q;
						pc = 8'h2e;
						do_pair = 1'b1;
					end
				end
				M_REAL: begin
					if (!is_digit(c)) begin
						res[0] = {K_REAL, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						nres = 2'd1;
						do_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (c == 8'h0a) begin
						res[0] = {K_ERROR, E_OPEN_STRING, sp, pos_inc - sp, sl, sc, 1'b0};
						nres = 2'd1;
						m = M_IDLE;
					end else if (c == 8'h5c) begin
						m = M_STRING_ESC;
					end else if (c == quote_q) begin
						res[0] = {K_STRING, E_NONE, sp, pos_inc - sp, sl, sc, 1'b0};
						nres = 2'd1;
						m = M_IDLE;
					end
				end
				M_STRING_ESC: m = M_STRING;
				M_PAIR: do_pair = 1'b1;
				M_LINE_COMMENT: if (c == 8'h0a) m = M_IDLE;
				M_BLOCK_COMMENT: if (c == 8'h2a) m = M_BLOCK_STAR;
				M_BLOCK_STAR: begin
					if (c == 8'h2f) m = M_IDLE;
					else if (c != 8'h2a) m = M_BLOCK_COMMENT;
				end
				default: do_idle = 1'b1;
			endcase

			// Two-character symbol decision on the held first character.
			if (do_pair) begin
				if (pc == 8'h2f && c == 8'h2f) begin
					m = M_LINE_COMMENT;
				end else if (pc == 8'h2f && c == 8'h2a) begin
					m = M_BLOCK_COMMENT;
				end else begin
					emit_ok = 1'b1;
					case (pc)
						8'h3a: if (c == 8'h3d) k = K_ASSIGN; else emit_ok = 1'b0;
						8'h3d: begin
							if (c == 8'h3d) k = K_EQEQ;
							else if (c == 8'h3e) k = K_ARROW;
							else emit_ok = 1'b0;
						end
						8'h3c: if (c == 8'h3d) k = K_LE; else emit_ok = 1'b0;
						8'h3e: if (c == 8'h3d) k = K_GE; else emit_ok = 1'b0;
						8'h2f: if (c == 8'h3d) k = K_NE; else emit_ok = 1'b0;
						8'h2e: if (c == 8'h2e) k = K_RANGE; else emit_ok = 1'b0;
						default: emit_ok = 1'b0;
					endcase
					if (emit_ok) begin
						res[nres] = {k, E_NONE, sp, pos_inc - sp, sl, sc, 1'b0};
						nres = nres + 1'b1;
						m = M_IDLE;
					end else begin
						case (pc)
							8'h3a: res[nres] = {K_ERROR, E_LONE_COLON, sp, pos_q - sp, sl, sc, 1'b0};
							8'h3d: res[nres] = {K_EQ, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
							8'h3c: res[nres] = {K_LT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
							8'h3e: res[nres] = {K_GT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
							8'h2f: res[nres] = {K_SLASH, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
							default: res[nres] = {K_DOT, E_NONE, sp, pos_q - sp, sl, sc, 1'b0};
						endcase
						nres = nres + 1'b1;
						do_idle = 1'b1;
					end
				end
			end

			// Start of a new token from the idle state.
			if (do_idle) begin
				m = M_IDLE;
				sp = pos_q; sl = line_q; sc = col_q;
				emit_ok = 1'b0;
				k = K_ERROR;
				if (c == 8'h20 || c == 8'h0d || c == 8'h09 || c == 8'h0a) begin
					m = M_IDLE;
				end else if (is_alpha(c) || c == 8'h5f) begin
					m = M_IDENT;
					kbuf_n = kw_word_t'(c);
					wlen_n = WLEN_BITS'(1);
				end else if (is_digit(c)) begin
					m = M_NUMBER;
				end else if (c == 8'h22 || c == 8'h27) begin
					m = M_STRING;
					quote_n = c;
				end else begin
					emit_ok = 1'b1;
					case (c)
						8'h3a, 8'h3d, 8'h3c, 8'h3e, 8'h2f, 8'h2e: begin
							m = M_PAIR;
							pc = c;
							emit_ok = 1'b0;
						end
						8'h2b: k = K_PLUS;
						8'h2d: k = K_MINUS;
						8'h2a: k = K_STAR;
						8'h28: k = K_LPAR;
						8'h29: k = K_RPAR;
						8'h5b: k = K_LBRK;
						8'h5d: k = K_RBRK;
						8'h7b: k = K_LBRC;
						8'h7d: k = K_RBRC;
						8'h3b: k = K_SEMI;
						8'h2c: k = K_COMMA;
						default: k = K_ERROR;
					endcase
					if (emit_ok) begin
						res[nres] = {k, (k == K_ERROR) ? E_UNKNOWN : E_NONE,
							sp, pos_inc - sp, sl, sc, 1'b0};
						nres = nres + 1'b1;
					end
				end
			end
		end

		if (nres != 2'd0) res[nres - 1'b1].last_of_run = 1'b1;
		mode_n = m;
		tpos_n = sp; tline_n = sl; tcol_n = sc;
		pend_n = pc;
	end

	// Position counters, saturating.
	always_comb begin
		pos_n = pos_inc;
		line_n = line_q;
		col_n = (col_q == LINE_MAX) ? col_q : col_q + 1'b1;
		if (c == 8'h0a) begin
			line_n = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
			col_n = LINE_BITS'(1);
		end
		if (eot) begin
			pos_n = '0;
			line_n = LINE_BITS'(1);
			col_n = LINE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0; tpos_q <= '0; dpos_q <= '0;
			line_q <= LINE_BITS'(1); col_q <= LINE_BITS'(1);
			tline_q <= LINE_BITS'(1); tcol_q <= LINE_BITS'(1);
			dline_q <= LINE_BITS'(1); dcol_q <= LINE_BITS'(1);
			kbuf_q <= '0; wlen_q <= '0; pend_q <= '0; quote_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q <= pos_n; tpos_q <= tpos_n; dpos_q <= dpos_n;
			line_q <= line_n; col_q <= col_n;
			tline_q <= tline_n; tcol_q <= tcol_n;
			dline_q <= dline_n; dcol_q <= dcol_n;
			kbuf_q <= kbuf_n; wlen_q <= wlen_n; pend_q <= pend_n; quote_q <= quote_n;
		end
	end

	// Result queue count: down by one on pop, up by the results of a taken byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= 2'd0;
		end else begin
			qcnt_q <= qcnt_q - 2'(q_pop) + (accept ? nres : 2'd0);
		end
	end

	// A byte is only taken when the queue is empty after this cycle's pop,
	// so new results always land from slot 0 upward.
	always_ff @(posedge clk) begin
		if (accept && nres != 2'd0)
			q_q[0] <= res[0];
		else if (q_pop)
			q_q[0] <= q_q[1];
		if (accept && nres > 2'd1)
			q_q[1] <= res[1];
		else if (q_pop)
			q_q[1] <= q_q[2];
		if (accept && nres == 2'd3)
			q_q[2] <= res[2];
	end

`ifndef ASSERT_OFF
	a_qcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q != 2'd3 || in_stall)
		else $error("queue full but input not stalled");
	a_eot_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |-> nres != 2'd0 && res[nres - 1'b1].token_kind == K_END)
		else $error("end marker did not yield end token");
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eot |=> mode_q == M_IDLE && pos_q == '0)
		else $error("state not cleared after end marker");
	a_last_head: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q == 2'd1 && !in_stall && !in_valid && !out_stall |=> qcnt_q == 2'd0)
		else $error("queue did not drain");
`endif

endmodule
